@@ rtl/core/mpr_pkg.sv @@
// Shared types and constants for the MQTT PUBLISH receive parser.
// Holds result kinds, error codes, ack types and the result burst descriptor.
// No dependencies.
`timescale 1ns / 1ps

package mpr_pkg;

  // result kinds
  localparam logic [2:0] KIND_TOPIC = 3'd0;
  localparam logic [2:0] KIND_PAY   = 3'd1;
  localparam logic [2:0] KIND_DONE  = 3'd2;
  localparam logic [2:0] KIND_TX    = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_NOT_PUBLISH = 3'd1;
  localparam logic [2:0] ERR_LEN_OVF     = 3'd2;
  localparam logic [2:0] ERR_TOPIC_OVR   = 3'd3;
  localparam logic [2:0] ERR_BAD_QOS     = 3'd4;
  localparam logic [2:0] ERR_PUBREL      = 3'd5;

  // control packet first bytes
  localparam logic [7:0] PKT_PUBACK  = 8'h40;
  localparam logic [7:0] PKT_PUBREC  = 8'h50;
  localparam logic [7:0] PKT_PUBREL  = 8'h62;
  localparam logic [7:0] PKT_PUBCOMP = 8'h70;
  localparam logic [7:0] PKT_ACK_LEN = 8'h02;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;

  // slots of one result burst: first result, done marker, four ack bytes
  localparam logic [2:0] POS_FIRST = 3'd0;
  localparam logic [2:0] POS_DONE  = 3'd1;
  localparam logic [2:0] POS_ACK0  = 3'd2;
  localparam logic [2:0] POS_ACK1  = 3'd3;
  localparam logic [2:0] POS_ACK2  = 3'd4;
  localparam logic [2:0] POS_ACK3  = 3'd5;

  typedef struct packed {
    logic [2:0]  start_pos;
    logic [2:0]  end_pos;
    logic [2:0]  first_kind;
    logic [7:0]  first_byte;
    logic [2:0]  err;
    logic [7:0]  ack_type;
    logic [15:0] pid;
    logic [1:0]  qos;
  } burst_t;

endpackage

@@ rtl/core/mqtt_publish_receive_parser_unit.sv @@
// MQTT PUBLISH receiver: one received byte per transfer, tagged results out.
// Throughput: one input byte per cycle while the result register can take it; a byte
// that yields N results is held in the result register and its results leave one per
// cycle while the receiver is ready, so input stalls until the last of them leaves.
// Results of a byte appear the cycle after its transfer.
// Reset (rst_ni, async low): parser waits for a fixed header, result register empty.
`timescale 1ns / 1ps

module mqtt_publish_receive_parser_unit import mpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] msg_qos_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  logic   in_fire;
  logic   burst_valid;
  burst_t burst;
  logic   can_load;

  // Accept a byte whenever the result register is free or its last result
  // is leaving in this cycle; any byte, with or without results, waits otherwise.
  assign in_ready_o = can_load;
  assign in_fire    = in_valid_i & in_ready_o;

  // Decode the byte against the packet phase and advance the parser state.
  mpr_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (in_fire),
    .rx_byte_i    (rx_byte_i),
    .burst_valid_o(burst_valid),
    .burst_o      (burst)
  );

  // Hold the burst and emit topic, payload, done, error and ack bytes in order.
  mpr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_fire & burst_valid),
    .burst_i     (burst),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .msg_qos_o   (msg_qos_o),
    .error_code_o(error_code_o),
    .last_o      (last_o)
  );

endmodule

@@ rtl/core/mpr_parser.sv @@
// Byte-level parser state for the MQTT PUBLISH receiver.
// Decodes one byte per transfer into a result burst descriptor; uses mpr_pkg.
`timescale 1ns / 1ps

module mpr_parser import mpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] rx_byte_i,
  output logic       burst_valid_o,
  output burst_t     burst_o
);

  typedef enum logic [3:0] {
    PH_HDR, PH_LEN, PH_TLH, PH_TLL, PH_TOPIC, PH_PIDH, PH_PIDL, PH_PAY, PH_REL
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  qos_q, qos_d;
  logic [27:0] rem_q, rem_d;
  logic [1:0]  lbi_q, lbi_d;
  logic [15:0] topic_q, topic_d;
  logic [15:0] pid_q, pid_d;
  logic [1:0]  hs_q, hs_d;

  logic        first_en, done_en, ack_en;
  logic [2:0]  first_kind, err;
  logic [7:0]  first_byte, ack_type, want;
  logic        go_topic, go_id, go_finish;
  logic [27:0] len_add, id_bytes;

  always_comb begin
    case (lbi_q)
      2'd0:    len_add = {21'd0, rx_byte_i[6:0]};
      2'd1:    len_add = {14'd0, rx_byte_i[6:0], 7'd0};
      2'd2:    len_add = {7'd0, rx_byte_i[6:0], 14'd0};
      default: len_add = {rx_byte_i[6:0], 21'd0};
    endcase
    case (hs_q)
      2'd0:    want = PKT_PUBREL;
      2'd1:    want = PKT_ACK_LEN;
      2'd2:    want = pid_q[15:8];
      default: want = pid_q[7:0];
    endcase
  end

  always_comb begin
    phase_d    = phase_q;
    qos_d      = qos_q;
    rem_d      = rem_q;
    lbi_d      = lbi_q;
    topic_d    = topic_q;
    pid_d      = pid_q;
    hs_d       = hs_q;
    first_en   = 1'b0;
    first_kind = KIND_TOPIC;
    first_byte = 8'd0;
    err        = ERR_NONE;
    done_en    = 1'b0;
    ack_en     = 1'b0;
    ack_type   = PKT_PUBACK;
    go_topic   = 1'b0;
    go_id      = 1'b0;
    go_finish  = 1'b0;
    id_bytes   = (qos_q != 2'd0) ? 28'd2 : 28'd0;

    case (phase_q)
      PH_HDR: begin
        if (rx_byte_i[7:4] != TYPE_PUBLISH) begin
          qos_d = 2'd0; first_en = 1'b1; first_kind = KIND_ERR; err = ERR_NOT_PUBLISH;
        end else if (rx_byte_i[2:1] == 2'd3) begin
          qos_d = 2'd0; first_en = 1'b1; first_kind = KIND_ERR; err = ERR_BAD_QOS;
        end else begin
          qos_d   = rx_byte_i[2:1];
          rem_d   = 28'd0;
          lbi_d   = 2'd0;
          topic_d = 16'd0;
          pid_d   = 16'd0;
          hs_d    = 2'd0;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        rem_d = rem_q + len_add;
        if (rx_byte_i[7]) begin
          if (lbi_q == 2'd3) begin
            first_en = 1'b1; first_kind = KIND_ERR; err = ERR_LEN_OVF;
            phase_d = PH_HDR;
          end else begin
            lbi_d = lbi_q + 2'd1;
          end
        end else if (rem_d < 28'd2 + id_bytes) begin
          first_en = 1'b1; first_kind = KIND_ERR; err = ERR_TOPIC_OVR;
          phase_d = PH_HDR;
        end else begin
          phase_d = PH_TLH;
        end
      end
      PH_TLH: begin
        topic_d = {rx_byte_i, 8'd0};
        rem_d   = rem_q - 28'd1;
        phase_d = PH_TLL;
      end
      PH_TLL: begin
        topic_d = {topic_q[15:8], rx_byte_i};
        rem_d   = rem_q - 28'd1;
        if ({12'd0, topic_d} > rem_d - id_bytes) begin
          first_en = 1'b1; first_kind = KIND_ERR; err = ERR_TOPIC_OVR;
          phase_d = PH_HDR;
        end else if (topic_d == 16'd0) begin
          go_topic = 1'b1;
        end else begin
          phase_d = PH_TOPIC;
        end
      end
      PH_TOPIC: begin
        first_en = 1'b1; first_kind = KIND_TOPIC; first_byte = rx_byte_i;
        rem_d   = rem_q - 28'd1;
        topic_d = topic_q - 16'd1;
        if (topic_d == 16'd0) go_topic = 1'b1;
      end
      PH_PIDH: begin
        pid_d   = {rx_byte_i, 8'd0};
        rem_d   = rem_q - 28'd1;
        phase_d = PH_PIDL;
      end
      PH_PIDL: begin
        pid_d = {pid_q[15:8], rx_byte_i};
        rem_d = rem_q - 28'd1;
        go_id = 1'b1;
      end
      PH_PAY: begin
        first_en = 1'b1; first_kind = KIND_PAY; first_byte = rx_byte_i;
        rem_d = rem_q - 28'd1;
        if (rem_d == 28'd0) go_finish = 1'b1;
      end
      PH_REL: begin
        if (rx_byte_i != want) begin
          first_en = 1'b1; first_kind = KIND_ERR; err = ERR_PUBREL;
          phase_d = PH_HDR;
        end else if (hs_q == 2'd3) begin
          ack_en = 1'b1; ack_type = PKT_PUBCOMP;
          hs_d = 2'd0;
          phase_d = PH_HDR;
        end else begin
          hs_d = hs_q + 2'd1;
        end
      end
      default: phase_d = PH_HDR;
    endcase

    // packet tail: packet id, payload or done
    if (go_topic) begin
      if (qos_q != 2'd0) phase_d = PH_PIDH;
      else go_id = 1'b1;
    end
    if (go_id) begin
      if (rem_d == 28'd0) go_finish = 1'b1;
      else phase_d = PH_PAY;
    end
    if (go_finish) begin
      done_en = 1'b1;
      phase_d = PH_HDR;
      if (qos_q == 2'd1) begin
        ack_en = 1'b1; ack_type = PKT_PUBACK;
      end else if (qos_q == 2'd2) begin
        ack_en = 1'b1; ack_type = PKT_PUBREC;
        hs_d = 2'd0;
        phase_d = PH_REL;
      end
    end
  end

  assign burst_valid_o       = first_en | done_en | ack_en;
  assign burst_o.start_pos  = first_en ? POS_FIRST : (done_en ? POS_DONE : POS_ACK0);
  assign burst_o.end_pos    = ack_en ? POS_ACK3 : (done_en ? POS_DONE : POS_FIRST);
  assign burst_o.first_kind = first_kind;
  assign burst_o.first_byte = first_byte;
  assign burst_o.err        = err;
  assign burst_o.ack_type   = ack_type;
  assign burst_o.pid        = pid_d;
  assign burst_o.qos        = qos_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR;
      qos_q   <= 2'd0;
      rem_q   <= 28'd0;
      lbi_q   <= 2'd0;
      topic_q <= 16'd0;
      pid_q   <= 16'd0;
      hs_q    <= 2'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      qos_q   <= qos_d;
      rem_q   <= rem_d;
      lbi_q   <= lbi_d;
      topic_q <= topic_d;
      pid_q   <= pid_d;
      hs_q    <= hs_d;
    end
  end

endmodule

@@ rtl/core/mpr_out.sv @@
// Result register and serializer for the MQTT PUBLISH receiver.
// Holds one result burst and emits its slots in order; uses mpr_pkg.
`timescale 1ns / 1ps

module mpr_out import mpr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       can_load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic [1:0] msg_qos_o,
  output logic [2:0] error_code_o,
  output logic       last_o
);

  logic       busy_q;
  logic [2:0] pos_q;
  burst_t     burst_q;
  logic       out_fire, at_end;

  assign at_end      = (pos_q == burst_q.end_pos);
  assign out_fire    = busy_q & out_ready_i;
  assign can_load_o  = ~busy_q | (out_ready_i & at_end);
  assign out_valid_o = busy_q;
  assign last_o      = at_end;
  assign msg_qos_o   = burst_q.qos;

  always_comb begin
    out_kind_o   = KIND_TX;
    out_byte_o   = 8'd0;
    error_code_o = ERR_NONE;
    case (pos_q)
      POS_FIRST: begin
        out_kind_o   = burst_q.first_kind;
        out_byte_o   = burst_q.first_byte;
        error_code_o = burst_q.err;
      end
      POS_DONE: out_kind_o = KIND_DONE;
      POS_ACK0: out_byte_o = burst_q.ack_type;
      POS_ACK1: out_byte_o = PKT_ACK_LEN;
      POS_ACK2: out_byte_o = burst_q.pid[15:8];
      POS_ACK3: out_byte_o = burst_q.pid[7:0];
      default:  out_byte_o = 8'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pos_q  <= POS_FIRST;
    end else if (load_i) begin
      busy_q <= 1'b1;
      pos_q  <= burst_i.start_pos;
    end else if (out_fire) begin
      if (at_end) busy_q <= 1'b0;
      else pos_q <= pos_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) burst_q <= burst_i;
  end

endmodule
